// ===== rtl/lphs_pkg.sv =====
package lphs_pkg;

  localparam int unsigned KEY_W    = 32;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned SLOT_W   = 6;

  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_SEARCH = 1'b1;

  localparam logic [STATUS_W-1:0] ST_INSERTED = 3'd0;
  localparam logic [STATUS_W-1:0] ST_PRESENT  = 3'd1;
  localparam logic [STATUS_W-1:0] ST_FULL     = 3'd2;
  localparam logic [STATUS_W-1:0] ST_FOUND    = 3'd3;
  localparam logic [STATUS_W-1:0] ST_NOTFOUND = 3'd4;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [SLOT_W-1:0]   slot;
  } result_t;

endpackage

// ===== rtl/lphs_mod.sv =====
module lphs_mod #(
  parameter int unsigned TABLE_SIZE = 64
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [lphs_pkg::KEY_W-1:0]    key_i,
  output logic                          done_o,
  output logic [$clog2(TABLE_SIZE)-1:0] home_o
);

  localparam int unsigned AW     = $clog2(TABLE_SIZE);
  localparam int unsigned KW     = lphs_pkg::KEY_W;
  localparam int unsigned SHIFT  = KW + AW;
  localparam int unsigned RCP_W  = KW + 1;
  localparam int unsigned PROD_W = KW + RCP_W;
  localparam int unsigned QUO_W  = PROD_W - SHIFT;
  // rounded-up reciprocal, exact quotient for every key
  localparam logic [63:0] RCP_WIDE =
    ((64'd1 << SHIFT) + 64'(TABLE_SIZE) - 64'd1) / 64'(TABLE_SIZE);
  localparam logic [RCP_W-1:0] RCP     = RCP_W'(RCP_WIDE);
  localparam logic [KW-1:0]    MODULUS = KW'(TABLE_SIZE);

  logic              mul_q, sub_q, done_q;
  logic [KW-1:0]     key_q;
  logic [QUO_W-1:0]  quo_q;
  logic [AW-1:0]     rem_q;
  logic [PROD_W-1:0] prod;
  logic [KW-1:0]     back;
  logic [KW-1:0]     diff;

  assign prod = PROD_W'(key_q) * PROD_W'(RCP);
  assign back = KW'(quo_q) * MODULUS;
  assign diff = key_q - back;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mul_q  <= 1'b0;
      sub_q  <= 1'b0;
      done_q <= 1'b0;
    end else begin
      mul_q  <= start_i;
      sub_q  <= mul_q;
      done_q <= sub_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      key_q <= key_i;
    end
    if (mul_q) begin
      quo_q <= prod[PROD_W-1:SHIFT];
    end
    if (sub_q) begin
      rem_q <= diff[AW-1:0];
    end
  end

  assign done_o = done_q;
  assign home_o = rem_q;

endmodule

// ===== rtl/lphs_probe.sv =====
module lphs_probe #(
  parameter int unsigned TABLE_SIZE = 64
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic                          cmd_i,
  input  logic [lphs_pkg::KEY_W-1:0]    key_i,
  output logic                          busy_o,
  output logic                          hash_start_o,
  input  logic                          hash_done_i,
  input  logic [$clog2(TABLE_SIZE)-1:0] hash_home_i,
  output logic                          done_o,
  output lphs_pkg::result_t             res_o
);

  localparam int unsigned AW    = $clog2(TABLE_SIZE);
  localparam int unsigned ENT_W = lphs_pkg::KEY_W + 1;
  localparam logic [AW-1:0] LAST = AW'(TABLE_SIZE - 1);

  localparam logic [1:0] S_CLEAR = 2'd0;
  localparam logic [1:0] S_IDLE  = 2'd1;
  localparam logic [1:0] S_HASH  = 2'd2;
  localparam logic [1:0] S_PROBE = 2'd3;

  // entry: {valid, key}
  logic [ENT_W-1:0] mem [TABLE_SIZE];
  logic [ENT_W-1:0] rd_data_q;

  logic [1:0]                 state_q, state_d;
  logic [AW-1:0]              p_q, p_d, p_next;
  logic [AW-1:0]              cnt_q, cnt_d;
  logic                       cmd_q, cmd_d;
  logic [lphs_pkg::KEY_W-1:0] key_q, key_d;
  logic                       done_q, done_d;
  lphs_pkg::result_t          res_q, res_d;

  logic [AW-1:0]    rd_addr, wr_addr;
  logic             wr_en;
  logic [ENT_W-1:0] wr_data;
  logic             ent_valid, ent_match;

  assign p_next    = (p_q == LAST) ? '0 : p_q + 1'b1;
  assign ent_valid = rd_data_q[ENT_W-1];
  assign ent_match = rd_data_q[lphs_pkg::KEY_W-1:0] == key_q;

  always_comb begin
    state_d      = state_q;
    p_d          = p_q;
    cnt_d        = cnt_q;
    cmd_d        = cmd_q;
    key_d        = key_q;
    done_d       = 1'b0;
    res_d        = res_q;
    rd_addr      = p_q;
    wr_en        = 1'b0;
    wr_addr      = p_q;
    wr_data      = '0;
    hash_start_o = 1'b0;
    case (state_q)
      S_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = cnt_q;
        if (cnt_q == LAST) begin
          cnt_d   = '0;
          state_d = S_IDLE;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      S_IDLE: begin
        if (start_i) begin
          cmd_d        = cmd_i;
          key_d        = key_i;
          hash_start_o = 1'b1;
          state_d      = S_HASH;
        end
      end
      S_HASH: begin
        if (hash_done_i) begin
          p_d     = hash_home_i;
          rd_addr = hash_home_i;
          cnt_d   = '0;
          state_d = S_PROBE;
        end
      end
      S_PROBE: begin
        if (!ent_valid) begin
          done_d  = 1'b1;
          state_d = S_IDLE;
          if (cmd_q == lphs_pkg::CMD_INSERT) begin
            wr_en        = 1'b1;
            wr_data      = {1'b1, key_q};
            res_d.status = lphs_pkg::ST_INSERTED;
            res_d.slot   = lphs_pkg::SLOT_W'(p_q);
          end else begin
            res_d.status = lphs_pkg::ST_NOTFOUND;
            res_d.slot   = '0;
          end
        end else if (ent_match) begin
          done_d       = 1'b1;
          state_d      = S_IDLE;
          res_d.status = (cmd_q == lphs_pkg::CMD_INSERT) ? lphs_pkg::ST_PRESENT
                                                         : lphs_pkg::ST_FOUND;
          res_d.slot   = lphs_pkg::SLOT_W'(p_q);
        end else if (cnt_q == LAST) begin
          done_d       = 1'b1;
          state_d      = S_IDLE;
          res_d.status = (cmd_q == lphs_pkg::CMD_INSERT) ? lphs_pkg::ST_FULL
                                                         : lphs_pkg::ST_NOTFOUND;
          res_d.slot   = '0;
        end else begin
          p_d     = p_next;
          rd_addr = p_next;
          cnt_d   = cnt_q + 1'b1;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      cnt_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    p_q   <= p_d;
    cmd_q <= cmd_d;
    key_q <= key_d;
    res_q <= res_d;
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_q <= mem[rd_addr];
  end

  assign busy_o = state_q != S_IDLE;
  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

// ===== rtl/linear_probe_hash_set_top.sv =====
// Flow: the start transfer drives the home-slot divider (registers mul_q, sub_q, done_q),
// then one table read, then one probe per slot until done_o, n = slots probed (1..TABLE_SIZE).
// One command at a time; start is taken again in the cycle done_o is high.
// Reset: after rst_ni rises the table is swept clear for TABLE_SIZE cycles with busy high.
// Results are shown for one cycle only; the receiver cannot stall.
module linear_probe_hash_set_top #(
  parameter int unsigned TABLE_SIZE = 64
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start,
  output logic                             busy,
  input  logic                             cmd_i,
  input  logic [lphs_pkg::KEY_W-1:0]       key_i,
  output logic                             done_o,
  output logic [lphs_pkg::STATUS_W-1:0]    status_o,
  output logic [lphs_pkg::SLOT_W-1:0]      slot_o
);

  localparam int unsigned AW = $clog2(TABLE_SIZE);

  logic              hash_start, hash_done;
  logic [AW-1:0]     hash_home;
  lphs_pkg::result_t res;

  lphs_mod #(
    .TABLE_SIZE (TABLE_SIZE)
  ) u_mod (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (hash_start),
    .key_i   (key_i),
    .done_o  (hash_done),
    .home_o  (hash_home)
  );

  lphs_probe #(
    .TABLE_SIZE (TABLE_SIZE)
  ) u_probe (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start),
    .cmd_i        (cmd_i),
    .key_i        (key_i),
    .busy_o       (busy),
    .hash_start_o (hash_start),
    .hash_done_i  (hash_done),
    .hash_home_i  (hash_home),
    .done_o       (done_o),
    .res_o        (res)
  );

  assign status_o = res.status;
  assign slot_o   = res.slot;

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("busy not raised after command transfer");

  a_one_strobe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result strobe held for more than one cycle");

  a_miss_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (status_o == lphs_pkg::ST_FULL || status_o == lphs_pkg::ST_NOTFOUND))
      |-> (slot_o == '0))
    else $error("slot not zero on full or not found");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (status_o <= lphs_pkg::ST_NOTFOUND))
    else $error("status code out of range");

  a_hash_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hash_done |-> !done_o)
    else $error("home slot ready while a result is shown");

endmodule
